FILE: rtl/cpar_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cpar_pkg
// Shared types and constants for the packet acknowledge receiver.
// ---------------------------------------------------------------------------
package cpar_pkg;

    localparam int unsigned ID_BITS_DEFAULT = 32;
    localparam int unsigned QUEUE_DEPTH     = 2;

    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam logic [31:0] CRC_SEED_RESET = 32'hFFFF_FFFF;

    localparam int unsigned PID_W  = 32;
    localparam int unsigned SIZE_W = 9;

    // input word opcodes
    typedef enum logic
    {
        OP_BYTE = 1'b0,
        OP_END  = 1'b1
    } opcode_t;

    // answer kinds
    typedef enum logic [1:0]
    {
        ACK_ACCEPT = 2'd0,
        ACK_RESEND = 2'd1,
        ACK_DUP    = 2'd2
    } ack_kind_t;

    // one queued answer
    typedef struct packed
    {
        logic [PID_W-1:0]  pid;
        logic [SIZE_W-1:0] size;
        ack_kind_t         kind;
    } ack_t;

endpackage : cpar_pkg
`default_nettype wire

FILE: rtl/cpar_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cpar_front
// Takes input words, runs the byte-wide crc and classifies each packet end.
// ---------------------------------------------------------------------------
module cpar_front
    import cpar_pkg::*;
#(
    parameter int unsigned ID_BITS = ID_BITS_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [31:0]       cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire opcode_t           in_opcode,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    input  wire logic [PID_W-1:0]  in_pid,
    input  wire logic [31:0]       in_claimed,
    input  wire logic [SIZE_W-1:0] in_size,
    input  wire logic              q_full,
    output logic                   q_push,
    output ack_t                   q_data
);

    localparam logic [ID_BITS-1:0] ID_ONE = {{(ID_BITS-1){1'b0}}, 1'b1};

    logic [31:0]        crc_seed_reg, crc_seed_next;
    logic [31:0]        running_crc_reg, running_crc_next;
    logic [ID_BITS-1:0] expected_id_reg, expected_id_next;

    logic [31:0]        crc_upd;
    logic [63:0]        pid_ext;
    logic [ID_BITS-1:0] pid_cmp;
    logic               accept;
    logic               id_match;
    logic               id_older;

    // reflected crc over one byte, one bit per step
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign crc_upd  = crc_byte(running_crc_reg, in_byte);
    assign pid_ext  = {32'd0, in_pid};
    assign pid_cmp  = pid_ext[ID_BITS-1:0];
    assign id_match = (pid_cmp == expected_id_reg);
    assign id_older = (pid_cmp < expected_id_reg);

    always_comb
    begin
        crc_seed_next    = crc_seed_reg;
        running_crc_next = running_crc_reg;
        expected_id_next = expected_id_reg;
        q_push           = 1'b0;
        q_data.pid       = in_pid;
        q_data.size      = in_size;
        q_data.kind      = ACK_DUP;
        if (cfg_we)
        begin
            crc_seed_next    = cfg_wdata;
            running_crc_next = cfg_wdata;
        end
        else if (accept)
        begin
            if (in_opcode == OP_END)
            begin
                expected_id_next = ID_ONE;
                running_crc_next = crc_seed_reg;
            end
            else if (!in_last)
            begin
                running_crc_next = crc_upd;
            end
            else
            begin
                running_crc_next = crc_seed_reg;
                if (id_match)
                begin
                    q_push = 1'b1;
                    if (crc_upd == in_claimed)
                    begin
                        q_data.kind      = ACK_ACCEPT;
                        expected_id_next = expected_id_reg + ID_ONE;
                    end
                    else
                    begin
                        q_data.kind = ACK_RESEND;
                    end
                end
                else if (id_older)
                begin
                    q_push      = 1'b1;
                    q_data.kind = ACK_DUP;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_seed_reg    <= CRC_SEED_RESET;
            running_crc_reg <= CRC_SEED_RESET;
            expected_id_reg <= ID_ONE;
        end
        else
        begin
            crc_seed_reg    <= crc_seed_next;
            running_crc_reg <= running_crc_next;
            expected_id_reg <= expected_id_next;
        end
    end

endmodule : cpar_front
`default_nettype wire

FILE: rtl/cpar_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cpar_queue
// Short first-in first-out queue of answers between front and back.
// ---------------------------------------------------------------------------
module cpar_queue
    import cpar_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire ack_t push_data,
    output logic      full,
    input  wire logic pop,
    output ack_t      pop_data,
    output logic      empty
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    ack_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule : cpar_queue
`default_nettype wire

FILE: rtl/cpar_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cpar_back
// Drains queued answers, builds the acknowledge word and holds it for output.
// ---------------------------------------------------------------------------
module cpar_back
    import cpar_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    input  wire ack_t        q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [PID_W-1:0] out_id,
    output logic [SIZE_W-1:0] out_size,
    output logic             out_error,
    output ack_kind_t        out_kind
);

    logic              valid_reg, valid_next;
    logic [PID_W-1:0]  id_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              error_reg;
    ack_kind_t         kind_reg;

    assign q_pop = !q_empty && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            id_reg    <= q_data.pid;
            size_reg  <= q_data.size;
            error_reg <= (q_data.kind == ACK_RESEND);
            kind_reg  <= q_data.kind;
        end
    end

    assign out_valid = valid_reg;
    assign out_id    = id_reg;
    assign out_size  = size_reg;
    assign out_error = error_reg;
    assign out_kind  = kind_reg;

endmodule : cpar_back
`default_nettype wire

FILE: rtl/crc32_packet_ack_receiver.sv
`default_nettype none
// ---------------------------------------------------------------------------
// crc32_packet_ack_receiver
// Stop-and-wait link receiver: byte-wide crc-32 check and acknowledge words.
// ---------------------------------------------------------------------------
// usage
//   s_axis carries one payload byte per word plus the packet header fields;
//   tuser is the opcode (payload byte or end of transfer), tlast marks the
//   final byte of a packet. m_axis carries one acknowledge word per answered
//   packet; tuser is the answer kind (accept, resend, duplicate).
//   cfg_we / cfg_wdata write the crc seed; the running crc reloads at once.
// throughput
//   one input word per cycle while the answer queue has room; the crc update
//   for a byte is combinational in the front stage, so words stream back to back.
// path
//   an acknowledge reaches m_axis after its last byte is taken by passing
//   through the answer queue and then the output register.
// stall
//   while m_axis is held off, answers collect in a two-entry queue; once it
//   is full s_axis_tready drops until the output drains.
// reset
//   seed and running crc go to all ones, expected id to one, queue and
//   output register empty.
// ---------------------------------------------------------------------------
module crc32_packet_ack_receiver
    import cpar_pkg::*;
#(
    parameter int unsigned ID_BITS = ID_BITS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config: crc seed
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    // input words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // data_byte[7:0], packet_id[39:8], claimed_crc[71:40], payload_size[80:72]
    input  wire logic [87:0] s_axis_tdata,
    // opcode[0]
    input  wire logic        s_axis_tuser,
    input  wire logic        s_axis_tlast,
    // acknowledge words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // ack_id[31:0], ack_size[40:32], error_flag[41]
    output logic [47:0]      m_axis_tdata,
    // ack_kind[1:0]
    output logic [1:0]       m_axis_tuser
);

    logic              q_push;
    ack_t              q_wdata;
    logic              q_full;
    logic              q_pop;
    ack_t              q_rdata;
    logic              q_empty;
    logic [PID_W-1:0]  ack_id;
    logic [SIZE_W-1:0] ack_size;
    logic              error_flag;
    ack_kind_t         ack_kind;

    // front: crc and classification
    cpar_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_opcode  (opcode_t'(s_axis_tuser)),
        .in_byte    (s_axis_tdata[7:0]),
        .in_last    (s_axis_tlast),
        .in_pid     (s_axis_tdata[39:8]),
        .in_claimed (s_axis_tdata[71:40]),
        .in_size    (s_axis_tdata[80:72]),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    // answer queue between the two sides
    cpar_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    // back: output register
    cpar_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_id    (ack_id),
        .out_size  (ack_size),
        .out_error (error_flag),
        .out_kind  (ack_kind)
    );

    // pack output word, zero pad to whole bytes
    assign m_axis_tdata = {6'd0, error_flag, ack_size, ack_id};
    assign m_axis_tuser = ack_kind;

endmodule : crc32_packet_ack_receiver
`default_nettype wire

FILE: sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Stream-level check of the crc-32 stop-and-wait acknowledge receiver.
// ---------------------------------------------------------------------------
// Packets of payload words are built with correct and corrupted crc values.
// The ids are current, old, ahead or random, and end-of-transfer words are
// mixed in. A scoreboard class keeps its own crc, seed and expected id.
// Every acknowledge word taken from the output is compared with the oldest
// predicted one. The crc seed is rewritten between phases, and both stream
// sides idle at random. One long receiver hold-off fills the answer queue.
// ---------------------------------------------------------------------------
module tb;
    import cpar_pkg::*;

    localparam int ITEM_GOAL      = 1450;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int MAX_LEN        = 40;

    // one predicted acknowledge word
    typedef struct
    {
        logic [31:0]      id;
        logic [SIZE_W-1:0] size;
        logic             err;
        ack_kind_t        kind;
    } ack_word_t;

    class ack_scoreboard;
        logic [31:0] seed;
        logic [31:0] run_crc;
        logic [31:0] next_id;
        ack_word_t   pending[$];
        int          n_words, n_acks, n_accept, n_resend, n_dup, n_silent, n_end;
        int          n_mismatch;

        function void clear();
            seed    = CRC_SEED_RESET;
            run_crc = seed;
            next_id = 32'd1;
            pending.delete();
        endfunction

        // a seed write also restarts the crc of a packet in progress
        function void load_seed(logic [31:0] s);
            seed    = s;
            run_crc = s;
        endfunction

        // reflected crc-32, one bit per shift
        static function logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            r = c ^ {24'd0, b};
            for (int k = 0; k < 8; k++)
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            return r;
        endfunction

        function void note_word(opcode_t op, logic [7:0] b, logic lst, logic [31:0] pid,
                                logic [31:0] claimed, logic [SIZE_W-1:0] size);
            logic [31:0] crc;
            ack_word_t   a;
            n_words++;
            if (op == OP_END)
            begin
                // partial packet is dropped, id sequence restarts
                next_id = 32'd1;
                run_crc = seed;
                n_end++;
                return;
            end
            crc = crc_update(run_crc, b);
            if (!lst)
            begin
                run_crc = crc;
                return;
            end
            run_crc = seed;
            a.id   = pid;
            a.size = size;
            if (pid == next_id)
            begin
                if (crc == claimed)
                begin
                    a.kind  = ACK_ACCEPT;
                    next_id = next_id + 32'd1;
                    n_accept++;
                end
                else
                begin
                    a.kind = ACK_RESEND;
                    n_resend++;
                end
            end
            else if (pid < next_id)
            begin
                a.kind = ACK_DUP;
                n_dup++;
            end
            else
            begin
                // id ahead of the sequence: no answer
                n_silent++;
                return;
            end
            a.err = (a.kind == ACK_RESEND);
            pending.push_back(a);
        endfunction

        function void check_ack(logic [31:0] id, logic [SIZE_W-1:0] size, logic err,
                                logic [1:0] kind);
            ack_word_t e;
            n_acks++;
            if (pending.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: unexpected ack id=%h size=%0d err=%0b kind=%0d",
                             id, size, err, kind);
                return;
            end
            e = pending.pop_front();
            if (id !== e.id || size !== e.size || err !== e.err || kind !== e.kind)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: ack mismatch exp id=%h size=%0d err=%0b kind=%0d, got id=%h size=%0d err=%0b kind=%0d",
                             e.id, e.size, e.err, e.kind, id, size, err, kind);
            end
        endfunction

        function void flush_leftover();
            if (pending.size() != 0)
            begin
                $display("ERROR: %0d predicted acks never arrived", pending.size());
                n_mismatch += pending.size();
            end
        endfunction
    endclass

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_we        = 1'b0;
    logic [31:0]        cfg_wdata     = 32'd0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // data_byte, packet_id, claimed_crc, payload_size, zero pad
    logic [87:0]        s_axis_tdata  = 88'd0;
    // opcode
    logic               s_axis_tuser  = 1'b0;
    logic               s_axis_tlast  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // ack_id, ack_size, error_flag, zero pad
    logic [47:0]        m_axis_tdata;
    // ack_kind
    logic [1:0]         m_axis_tuser;

    ack_scoreboard sb;
    int            items_sent = 0;
    int            seeds_used = 0;
    bit            quiet      = 1'b0;
    int            rx_hold    = 0;

    crc32_packet_ack_receiver uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

    // ack receiver: random back-pressure, or a counted hold-off when asked
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_axis_tready = 1'b0;
            rx_hold--;
        end
        else
        begin
            m_axis_tready = quiet || ($urandom_range(0, 99) >= 35);
        end
    end

    // both handshakes are observed at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_ack(m_axis_tdata[31:0], m_axis_tdata[40:32], m_axis_tdata[41],
                             m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_word(opcode_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tlast,
                             s_axis_tdata[39:8], s_axis_tdata[71:40], s_axis_tdata[80:72]);
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(opcode_t op, logic [7:0] b, logic lst, logic [31:0] pid,
                             logic [31:0] claimed, logic [SIZE_W-1:0] size);
        while (!quiet && $urandom_range(0, 99) < 35)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tlast  = lst;
        s_axis_tdata  = {7'd0, size, claimed, pid, b};
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        @(negedge clk);
    endtask

    // first four bytes come from pattern, the rest are random;
    // flip < 0 gives the right crc, otherwise that crc bit is inverted
    task automatic send_packet(logic [31:0] pid, int len, logic [31:0] pattern, int flip,
                               logic [SIZE_W-1:0] size);
        logic [7:0]  pay[MAX_LEN];
        logic [31:0] crc;
        logic [31:0] claimed;
        crc = sb.seed;
        for (int i = 0; i < len; i++)
        begin
            pay[i] = (i < 4) ? pattern[8*i +: 8] : 8'($urandom);
            crc    = ack_scoreboard::crc_update(crc, pay[i]);
        end
        claimed = (flip < 0) ? crc : crc ^ (32'd1 << flip);
        for (int i = 0; i < len; i++)
            send_word(OP_BYTE, pay[i], i == len - 1, pid, claimed, size);
    endtask

    task automatic random_packet();
        int          pick;
        int          len;
        logic [31:0] pid;
        pick = $urandom_range(0, 99);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_LEN) : $urandom_range(1, 8);
        if (pick < 60 || (pick < 82 && pick >= 72 && sb.next_id == 0))
        begin
            send_packet(sb.next_id, len, $urandom, -1, 9'($urandom));
        end
        else if (pick < 72)
        begin
            send_packet(sb.next_id, len, $urandom, $urandom_range(0, 31), 9'($urandom));
        end
        else if (pick < 82)
        begin
            pid = $urandom_range(0, sb.next_id - 1);
            send_packet(pid, len, $urandom, $urandom_range(0, 1) ? -1 : 7, 9'($urandom));
        end
        else if (pick < 88)
        begin
            pid = $urandom_range(0, 1) ? sb.next_id + 1 + $urandom_range(0, 20)
                                       : ($urandom | 32'h8000_0000);
            send_packet(pid, len, $urandom, -1, 9'($urandom));
        end
        else if (pick < 93)
        begin
            send_word(OP_END, 8'($urandom), 1'($urandom), $urandom, $urandom, 9'($urandom));
        end
        else if (pick < 97)
        begin
            // packet cut short by an end of transfer
            repeat ($urandom_range(1, 5))
                send_word(OP_BYTE, 8'($urandom), 1'b0, sb.next_id, $urandom, 9'($urandom));
            send_word(OP_END, 8'($urandom), 1'($urandom), $urandom, $urandom, 9'($urandom));
        end
        else
        begin
            send_packet($urandom, len, $urandom, $urandom_range(0, 1) ? -1 : 0, 9'($urandom));
        end
    endtask

    task automatic random_phase(int goal);
        while (items_sent < goal)
            random_packet();
    endtask

    // stop offering words, let every answer out, then cover the pipeline latency
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_seed(logic [31:0] s);
        cfg_wdata = s;
        cfg_we    = 1'b1;
        @(posedge clk);
        sb.load_seed(s);
        seeds_used++;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin
        int waited;
        sb = new();
        sb.clear();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: accept, resend, duplicate, ahead, end of transfer
        send_packet(32'd1, 1, 32'h0000_0000, -1, 9'd0);
        send_packet(32'd2, 3, 32'h0001_80FF, -1, 9'd511);
        send_packet(32'd3, 1, 32'h0000_007E, 31, 9'd1);
        send_packet(32'd3, 1, 32'h0000_007E, -1, 9'd256);
        send_packet(32'd0, 1, 32'h0000_0055, -1, 9'd2);
        send_packet(32'hFFFF_FFFF, 1, 32'h0000_00AA, -1, 9'd3);
        send_packet(32'd5, 1, 32'h0000_0011, -1, 9'd4);
        send_word(OP_END, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'h1FF);
        send_packet(32'd3, 1, 32'h0000_0022, -1, 9'd5);
        // partial packet dropped by end of transfer, crc must start fresh
        send_word(OP_BYTE, 8'h33, 1'b0, 32'd1, 32'd0, 9'd0);
        send_word(OP_END, 8'h00, 1'b0, 32'd0, 32'd0, 9'd0);
        send_packet(32'd1, 2, 32'h0000_4433, -1, 9'd6);
        // old id with a bad crc still gets a duplicate ack
        send_packet(32'd1, 1, 32'h0000_0099, 0, 9'd7);
        send_packet(32'd2, 4, 32'hFFFF_FFFF, -1, 9'd8);

        // seed write in the middle of a packet restarts its crc
        send_word(OP_BYTE, 8'hA5, 1'b0, sb.next_id, 32'd0, 9'd0);
        send_word(OP_BYTE, 8'h5A, 1'b0, sb.next_id, 32'd0, 9'd0);
        wait_drained();
        write_seed(32'h0000_0000);
        send_packet(sb.next_id, 2, 32'h0000_C3C3, -1, 9'd9);
        random_phase(400);

        wait_drained();
        write_seed(32'hFFFF_FFFF);
        // long receiver hold-off while the sender keeps going
        rx_hold = RX_HOLD_CYCLES;
        quiet   = 1'b1;
        repeat (10)
            send_packet(sb.next_id, 1, $urandom, -1, 9'($urandom));
        quiet   = 1'b0;
        random_phase(700);

        // a stretch with no idling on either side
        wait_drained();
        write_seed($urandom);
        quiet = 1'b1;
        random_phase(950);
        quiet = 1'b0;

        wait_drained();
        write_seed(32'h8000_0001);
        random_phase(1200);

        wait_drained();
        write_seed($urandom);
        random_phase(ITEM_GOAL);

        s_axis_tvalid = 1'b0;
        waited = 0;
        while (sb.pending.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (8) @(negedge clk);
        sb.flush_leftover();

        $display("sent %0d words over %0d seed settings, %0d end-of-transfer words",
                 sb.n_words, seeds_used + 1, sb.n_end);
        $display("acks checked %0d: %0d accept, %0d resend, %0d duplicate; %0d unanswered",
                 sb.n_acks, sb.n_accept, sb.n_resend, sb.n_dup, sb.n_silent);
        if (sb.n_mismatch == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/cpar_pkg.sv
rtl/cpar_front.sv
rtl/cpar_queue.sv
rtl/cpar_back.sv
rtl/crc32_packet_ack_receiver.sv
sim/tb.sv
